### src/tcw_pkg.sv
// Shared types, codes and constants of the terminal cell writer.
package tcw_pkg;

  // Field widths of the item payloads and the configuration port.
  localparam int OP_W        = 2;
  localparam int CHAR_W      = 8;
  localparam int COL_W       = 7;
  localparam int ROW_W       = 6;
  localparam int KIND_W      = 2;
  localparam int NUM_COLS_W  = 8;
  localparam int NUM_ROWS_W  = 7;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_IDX_W   = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS    = 1'b1;

  // Register values after reset.
  localparam logic [NUM_COLS_W-1:0] NUM_COLUMNS_RST = 8'd80;
  localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST    = 7'd25;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_FILL  = 8'd46;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'd32;

  typedef enum logic [OP_W-1:0] {
    OP_PUT  = 2'd0,
    OP_SET  = 2'd1,
    OP_READ = 2'd2,
    OP_NEXT = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_FOUND = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef struct packed {
    op_t               opcode;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  col_x;
    logic [ROW_W-1:0]  row_y;
  } in_item_t;

  typedef struct packed {
    kind_t             result_kind;
    logic [CHAR_W-1:0] cell_char;
    logic [COL_W-1:0]  cell_col;
    logic [ROW_W-1:0]  cell_row;
  } out_item_t;

  // Cell store write selection.
  typedef enum logic [2:0] {
    WR_NONE  = 3'd0,
    WR_CLEAR = 3'd1,
    WR_CUR   = 3'd2,
    WR_BS    = 3'd3,
    WR_XY    = 3'd4,
    WR_SCAN  = 3'd5
  } wr_sel_t;

  // Cell store read address selection.
  typedef enum logic [1:0] {
    RD_HOLD = 2'd0,
    RD_XY   = 2'd1,
    RD_SCAN = 2'd2
  } rd_sel_t;

  // Cursor update.
  typedef enum logic [2:0] {
    CUR_HOLD = 3'd0,
    CUR_REM  = 3'd1,
    CUR_INC  = 3'd2,
    CUR_DEC  = 3'd3,
    CUR_LF   = 3'd4
  } cur_op_t;

  // Scan position update.
  typedef enum logic [2:0] {
    SCAN_HOLD     = 3'd0,
    SCAN_NEXT_ROW = 3'd1,
    SCAN_NEXT_COL = 3'd2,
    SCAN_FOUND    = 3'd3,
    SCAN_RESET    = 3'd4
  } scan_op_t;

  // Result register load.
  typedef enum logic [1:0] {
    OUT_NONE  = 2'd0,
    OUT_READ  = 2'd1,
    OUT_FOUND = 2'd2,
    OUT_DONE  = 2'd3
  } out_op_t;

  typedef struct packed {
    logic     load_item;
    wr_sel_t  wr_sel;
    logic     put_blank;
    rd_sel_t  rd_sel;
    cur_op_t  cur_op;
    scan_op_t scan_op;
    out_op_t  out_op;
    logic     tab_step;
    logic     div_start;
    logic     div_by_cols;
  } dp_cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic clr_last;
    logic cur_ok;
    logic div_done;
    logic is_nl;
    logic is_bs;
    logic is_tab;
    logic tab_last;
    logic scan_col_in;
    logic scan_row_in;
    logic dirty;
    logic out_free;
  } dp_sts_t;

endpackage

### src/tcw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tcw_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 8192
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data registered; a read of the word being written returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/tcw_dp.sv
// Datapath of the terminal cell writer: registers, cell store, divider and result register.
module tcw_dp #(
  parameter int MAX_COLS   = 128,
  parameter int MAX_ROWS   = 64,
  parameter int TAB_SPACES = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  tcw_pkg::in_item_t                  in_payload,
  input  logic                               out_stall,
  output logic                               out_valid,
  output tcw_pkg::out_item_t                 out_payload,
  input  tcw_pkg::dp_cmd_t                   cmd,
  output tcw_pkg::dp_sts_t                   sts
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int NW    = $clog2(AW + 1);
  localparam int TBW   = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;
  localparam int WW    = tcw_pkg::CHAR_W + 1;

  logic [tcw_pkg::NUM_COLS_W-1:0] num_columns_r;
  logic [tcw_pkg::NUM_ROWS_W-1:0] num_rows_r;
  logic [CW-1:0]                  cols_eff;
  logic [RW-1:0]                  rows_eff;
  logic [TW-1:0]                  total_r;

  tcw_pkg::in_item_t              item_r;
  logic [TBW-1:0]                 tab_cnt_r, tab_cnt_nxt;
  logic [AW-1:0]                  cursor_r, cursor_nxt;
  logic [TW-1:0]                  cur_inc, cur_lf;
  logic [AW-1:0]                  cur_dec;

  logic [TW-1:0]                  div_rem_r, div_rem_nxt;
  logic [AW-1:0]                  div_dvd_r, div_dvd_nxt;
  logic [TW-1:0]                  div_dvs_r, div_dvs_nxt;
  logic [NW-1:0]                  div_cnt_r, div_cnt_nxt;
  logic [TW:0]                    div_trial, div_diff;

  logic [AW-1:0]                  clr_cnt_r;
  logic [CW-1:0]                  scan_col_r, scan_col_nxt;
  logic [RW-1:0]                  scan_row_r, scan_row_nxt;

  logic                           in_range;
  logic [TW-1:0]                  xy_prod, scan_prod;
  logic [AW-1:0]                  xy_addr, scan_addr;
  logic [AW-1:0]                  addr_r, addr_nxt;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr, ram_raddr;
  logic [WW-1:0]                  ram_wdata, ram_rdata;
  logic [tcw_pkg::CHAR_W-1:0]     rd_char;

  logic                           out_valid_r, out_valid_nxt;
  tcw_pkg::out_item_t             out_r, out_nxt;

  // Configuration registers, to be written only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_columns_r <= tcw_pkg::NUM_COLUMNS_RST;
      num_rows_r    <= tcw_pkg::NUM_ROWS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcw_pkg::CFG_NUM_COLUMNS: num_columns_r <= cfg_data;
        tcw_pkg::CFG_NUM_ROWS:    num_rows_r    <= cfg_data[tcw_pkg::NUM_ROWS_W-1:0];
      endcase
    end
  end

  // Geometry in use: zero acts as one, large values clamp to the maximum.
  always_comb begin
    if (num_columns_r == '0) begin
      cols_eff = CW'(1);
    end else if (32'(num_columns_r) > MAX_COLS) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(num_columns_r);
    end
    if (num_rows_r == '0) begin
      rows_eff = RW'(1);
    end else if (32'(num_rows_r) > MAX_ROWS) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(num_rows_r);
    end
  end

  // Screen size, registered off the multiplier.
  always_ff @(posedge clk) begin
    total_r <= TW'(cols_eff) * TW'(rows_eff);
  end

  // Accepted item and tab repeat counter.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_payload;
    end
  end

  always_comb begin
    tab_cnt_nxt = tab_cnt_r;
    if (cmd.load_item) begin
      tab_cnt_nxt = '0;
    end else if (cmd.tab_step) begin
      tab_cnt_nxt = tab_cnt_r + TBW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_cnt_r <= '0;
    end else begin
      tab_cnt_r <= tab_cnt_nxt;
    end
  end

  // Cursor updates; the cursor stays below the screen size once normalized.
  always_comb begin
    cur_inc = TW'(cursor_r) + TW'(1);
    cur_dec = (cursor_r == '0) ? '0 : cursor_r - AW'(1);
    cur_lf  = TW'(cursor_r) - div_rem_r + TW'(cols_eff);
    unique case (cmd.cur_op)
      tcw_pkg::CUR_HOLD: cursor_nxt = cursor_r;
      tcw_pkg::CUR_REM:  cursor_nxt = AW'(div_rem_r);
      tcw_pkg::CUR_INC:  cursor_nxt = (cur_inc == total_r) ? '0 : AW'(cur_inc);
      tcw_pkg::CUR_DEC:  cursor_nxt = cur_dec;
      tcw_pkg::CUR_LF:   cursor_nxt = (cur_lf == total_r) ? '0 : AW'(cur_lf);
      default:           cursor_nxt = cursor_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
    end else begin
      cursor_r <= cursor_nxt;
    end
  end

  // Restoring remainder unit: one dividend bit per cycle, cursor by screen size or columns.
  always_comb begin
    div_trial   = {div_rem_r, div_dvd_r[AW-1]};
    div_diff    = div_trial - {1'b0, div_dvs_r};
    div_rem_nxt = div_rem_r;
    div_dvd_nxt = div_dvd_r;
    div_dvs_nxt = div_dvs_r;
    div_cnt_nxt = div_cnt_r;
    if (cmd.div_start) begin
      div_rem_nxt = '0;
      div_dvd_nxt = cursor_r;
      div_dvs_nxt = cmd.div_by_cols ? TW'(cols_eff) : total_r;
      div_cnt_nxt = NW'(AW);
    end else if (div_cnt_r != '0) begin
      div_rem_nxt = (div_trial >= {1'b0, div_dvs_r}) ? TW'(div_diff) : TW'(div_trial);
      div_dvd_nxt = div_dvd_r << 1;
      div_cnt_nxt = div_cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else begin
      div_cnt_r <= div_cnt_nxt;
    end
    div_rem_r <= div_rem_nxt;
    div_dvd_r <= div_dvd_nxt;
    div_dvs_r <= div_dvs_nxt;
  end

  // Clearing pass counter after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.wr_sel == tcw_pkg::WR_CLEAR) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // Saved scan position, walked in place during a dirty scan.
  always_comb begin
    scan_col_nxt = scan_col_r;
    scan_row_nxt = scan_row_r;
    unique case (cmd.scan_op)
      tcw_pkg::SCAN_HOLD: begin
      end
      tcw_pkg::SCAN_NEXT_ROW: begin
        scan_row_nxt = scan_row_r + RW'(1);
      end
      tcw_pkg::SCAN_NEXT_COL: begin
        scan_col_nxt = scan_col_r + CW'(1);
        scan_row_nxt = '0;
      end
      tcw_pkg::SCAN_FOUND: begin
        if ((32'(scan_row_r) + 1) < 32'(rows_eff)) begin
          scan_row_nxt = scan_row_r + RW'(1);
        end else begin
          scan_col_nxt = scan_col_r + CW'(1);
          scan_row_nxt = '0;
        end
      end
      tcw_pkg::SCAN_RESET: begin
        scan_col_nxt = '0;
        scan_row_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_col_r <= '0;
      scan_row_r <= '0;
    end else begin
      scan_col_r <= scan_col_nxt;
      scan_row_r <= scan_row_nxt;
    end
  end

  // Linear cell addresses: row times columns plus column.
  assign in_range  = (32'(item_r.col_x) < 32'(cols_eff)) && (32'(item_r.row_y) < 32'(rows_eff));
  assign xy_prod   = TW'(item_r.row_y) * TW'(cols_eff) + TW'(item_r.col_x);
  assign scan_prod = TW'(scan_row_r) * TW'(cols_eff) + TW'(scan_col_r);
  assign xy_addr   = AW'(xy_prod);
  assign scan_addr = AW'(scan_prod);

  // Read address; held while a result waits for the output register.
  always_comb begin
    unique case (cmd.rd_sel)
      tcw_pkg::RD_HOLD: addr_nxt = addr_r;
      tcw_pkg::RD_XY:   addr_nxt = xy_addr;
      tcw_pkg::RD_SCAN: addr_nxt = scan_addr;
      default:          addr_nxt = addr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
  end

  assign ram_raddr = addr_nxt;
  assign rd_char   = ram_rdata[tcw_pkg::CHAR_W-1:0];

  // Write port: each word is the dirty mark over the character.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cursor_r;
    ram_wdata = {1'b1, tcw_pkg::CH_BLANK};
    unique case (cmd.wr_sel)
      tcw_pkg::WR_NONE: begin
      end
      tcw_pkg::WR_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = {1'b1, tcw_pkg::CH_FILL};
      end
      tcw_pkg::WR_CUR: begin
        ram_we    = 1'b1;
        ram_waddr = cursor_r;
        ram_wdata = {1'b1, cmd.put_blank ? tcw_pkg::CH_BLANK : item_r.char_code};
      end
      tcw_pkg::WR_BS: begin
        ram_we    = 1'b1;
        ram_waddr = cur_dec;
        ram_wdata = {1'b1, tcw_pkg::CH_BLANK};
      end
      tcw_pkg::WR_XY: begin
        ram_we    = in_range;
        ram_waddr = xy_addr;
        ram_wdata = {1'b1, item_r.char_code};
      end
      tcw_pkg::WR_SCAN: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = {1'b0, rd_char};
      end
      default: begin
      end
    endcase
  end

  tcw_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result register; it frees when the receiver takes the item.
  always_comb begin
    out_nxt = out_r;
    unique case (cmd.out_op)
      tcw_pkg::OUT_NONE: begin
      end
      tcw_pkg::OUT_READ: begin
        out_nxt.result_kind = tcw_pkg::KIND_READ;
        out_nxt.cell_char   = in_range ? rd_char : '0;
        out_nxt.cell_col    = item_r.col_x;
        out_nxt.cell_row    = item_r.row_y;
      end
      tcw_pkg::OUT_FOUND: begin
        out_nxt.result_kind = tcw_pkg::KIND_FOUND;
        out_nxt.cell_char   = rd_char;
        out_nxt.cell_col    = tcw_pkg::COL_W'(scan_col_r);
        out_nxt.cell_row    = tcw_pkg::ROW_W'(scan_row_r);
      end
      tcw_pkg::OUT_DONE: begin
        out_nxt.result_kind = tcw_pkg::KIND_DONE;
        out_nxt.cell_char   = '0;
        out_nxt.cell_col    = '0;
        out_nxt.cell_row    = '0;
      end
    endcase
    if (cmd.out_op != tcw_pkg::OUT_NONE) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  // Status back to the controller.
  always_comb begin
    sts.in_op       = in_payload.opcode;
    sts.clr_last    = (clr_cnt_r == AW'(DEPTH - 1));
    sts.cur_ok      = (TW'(cursor_r) < total_r);
    sts.div_done    = (div_cnt_r == '0);
    sts.is_nl       = (item_r.char_code == tcw_pkg::CH_LF) ||
                      (item_r.char_code == tcw_pkg::CH_CR);
    sts.is_bs       = (item_r.char_code == tcw_pkg::CH_BS);
    sts.is_tab      = (item_r.char_code == tcw_pkg::CH_TAB);
    sts.tab_last    = (tab_cnt_r == TBW'(TAB_SPACES - 1));
    sts.scan_col_in = (32'(scan_col_r) < 32'(cols_eff));
    sts.scan_row_in = (32'(scan_row_r) < 32'(rows_eff));
    sts.dirty       = ram_rdata[tcw_pkg::CHAR_W];
    sts.out_free    = !out_valid_r || !out_stall;
  end

endmodule

### src/tcw_ctrl.sv
// Controller state machine of the terminal cell writer.
module tcw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tcw_pkg::dp_sts_t sts,
  output tcw_pkg::dp_cmd_t cmd
);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_NORM  = 12'b0000_0000_0100,
    S_NDIV  = 12'b0000_0000_1000,
    S_PUT   = 12'b0000_0001_0000,
    S_TAB   = 12'b0000_0010_0000,
    S_LDIV  = 12'b0000_0100_0000,
    S_SET   = 12'b0000_1000_0000,
    S_RD    = 12'b0001_0000_0000,
    S_RDOUT = 12'b0010_0000_0000,
    S_SCAN  = 12'b0100_0000_0000,
    S_SCHK  = 12'b1000_0000_0000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;

  // Items are taken only between operations.
  assign in_stall = (state_r != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.wr_sel = tcw_pkg::WR_CLEAR;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          unique case (sts.in_op)
            tcw_pkg::OP_PUT:  state_nxt = S_NORM;
            tcw_pkg::OP_SET:  state_nxt = S_SET;
            tcw_pkg::OP_READ: state_nxt = S_RD;
            tcw_pkg::OP_NEXT: state_nxt = S_SCAN;
          endcase
        end
      end
      S_NORM: begin
        // A cursor left beyond a shrunken screen is reduced first.
        if (sts.cur_ok) begin
          state_nxt = S_PUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_NDIV;
        end
      end
      S_NDIV: begin
        if (sts.div_done) begin
          cmd.cur_op = tcw_pkg::CUR_REM;
          state_nxt  = S_PUT;
        end
      end
      S_PUT: begin
        priority if (sts.is_nl) begin
          cmd.div_start   = 1'b1;
          cmd.div_by_cols = 1'b1;
          state_nxt       = S_LDIV;
        end else if (sts.is_bs) begin
          cmd.wr_sel = tcw_pkg::WR_BS;
          cmd.cur_op = tcw_pkg::CUR_DEC;
          state_nxt  = S_IDLE;
        end else if (sts.is_tab) begin
          state_nxt = S_TAB;
        end else begin
          cmd.wr_sel = tcw_pkg::WR_CUR;
          cmd.cur_op = tcw_pkg::CUR_INC;
          state_nxt  = S_IDLE;
        end
      end
      S_TAB: begin
        cmd.wr_sel    = tcw_pkg::WR_CUR;
        cmd.put_blank = 1'b1;
        cmd.cur_op    = tcw_pkg::CUR_INC;
        cmd.tab_step  = 1'b1;
        if (sts.tab_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_LDIV: begin
        if (sts.div_done) begin
          cmd.cur_op = tcw_pkg::CUR_LF;
          state_nxt  = S_IDLE;
        end
      end
      S_SET: begin
        cmd.wr_sel = tcw_pkg::WR_XY;
        state_nxt  = S_IDLE;
      end
      S_RD: begin
        cmd.rd_sel = tcw_pkg::RD_XY;
        state_nxt  = S_RDOUT;
      end
      S_RDOUT: begin
        if (sts.out_free) begin
          cmd.out_op = tcw_pkg::OUT_READ;
          state_nxt  = S_IDLE;
        end
      end
      S_SCAN: begin
        // Column past the screen ends the pass; row past the screen moves on.
        priority if (!sts.scan_col_in) begin
          if (sts.out_free) begin
            cmd.out_op  = tcw_pkg::OUT_DONE;
            cmd.scan_op = tcw_pkg::SCAN_RESET;
            state_nxt   = S_IDLE;
          end
        end else if (!sts.scan_row_in) begin
          cmd.scan_op = tcw_pkg::SCAN_NEXT_COL;
        end else begin
          cmd.rd_sel = tcw_pkg::RD_SCAN;
          state_nxt  = S_SCHK;
        end
      end
      S_SCHK: begin
        if (sts.dirty) begin
          if (sts.out_free) begin
            cmd.out_op  = tcw_pkg::OUT_FOUND;
            cmd.wr_sel  = tcw_pkg::WR_SCAN;
            cmd.scan_op = tcw_pkg::SCAN_FOUND;
            state_nxt   = S_IDLE;
          end
        end else begin
          cmd.scan_op = tcw_pkg::SCAN_NEXT_ROW;
          state_nxt   = S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/terminal_cell_writer_core.sv
// Top level of the terminal cell writer: a character-cell text buffer with cursor and dirty scan.
// Items enter on in_valid/in_stall with an opcode: put at cursor, set at (x,y), read at (x,y)
// or fetch the next dirty cell. Read and next-dirty each give one item on out_valid/out_stall;
// put and set give none. The geometry registers are written on cfg_we/cfg_index/cfg_data; the
// user must write them only while the block is idle, which the block itself does not enforce.
// One item is worked on at a time; the next is taken once it finishes. A tab writes TAB_SPACES
// blanks at the cursor. A newline or carriage return divides the cursor by the column count in
// the remainder unit, which takes one bit per cycle. A put after a geometry change that leaves
// the cursor off the screen first divides the cursor by the screen size in the same unit.
// Next-dirty reads the cells it visits one at a time through the cell store read port.
// After reset the cell store is swept one word per cycle, filling every cell with '.' and
// marking it dirty; in_stall stays high meanwhile, while configuration writes are taken.
// Results sit in an output register; while out_stall holds it full, the block still accepts
// items and pauses only when a new result is ready.
module terminal_cell_writer_core #(
  parameter int MAX_COLS   = 128,
  parameter int MAX_ROWS   = 64,
  parameter int TAB_SPACES = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tcw_pkg::in_item_t              in_payload,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tcw_pkg::out_item_t             out_payload
);

  tcw_pkg::dp_cmd_t cmd;
  tcw_pkg::dp_sts_t sts;

  // Sequencing of each operation.
  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage, address arithmetic and result register.
  tcw_dp #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .TAB_SPACES (TAB_SPACES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_payload  (in_payload),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_payload (out_payload),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
